// File: rtl/rrb_pkg.sv
// Package for the RTCP reception report block: constants and controller command type.
`default_nettype none
package rrb_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned NS_W   = 30;
    localparam int unsigned JIT_W  = 28;
    localparam int unsigned CUM_W  = 24;
    localparam int unsigned FRAC_W = 8;
    localparam int unsigned DLSR_W = 16;

    // Divider step count for the fraction lost
    localparam int unsigned FRAC_STEPS = FRAC_W;
    localparam int unsigned CNT_W      = $clog2(FRAC_STEPS);

    // DLSR fraction: floor(ns * 65536 / 1e9) = floor(ns * 128 / 1953125).
    // The estimate floor(ns * NS_RECIP / 2^30) is low by at most one.
    localparam int unsigned SCALE_W  = NS_W + 7;
    localparam int unsigned RECIP_W  = 17;
    localparam int unsigned RECIP_SH = 30;
    localparam int unsigned UNIT_W   = 21;

    localparam logic [WORD_W-1:0]  NS_PER_SEC  = 32'd1000000000;
    localparam logic [WORD_W-1:0]  NS_MAX      = 32'd999999999;
    localparam logic [CUM_W-1:0]   CUM_MAX     = 24'h7FFFFF;
    localparam logic [CUM_W-1:0]   CUM_MIN     = 24'h800000;
    localparam logic [FRAC_W-1:0]  FRAC_SAT    = 8'hFF;
    localparam logic [RECIP_W-1:0] NS_RECIP    = 17'd70368;   // floor(2^37 / 1953125)
    localparam logic [UNIT_W-1:0]  NS_UNIT     = 21'd1953125; // 1e9 / 512

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // take in a request item, update previous totals
        logic setup;     // form loss terms, adjust nanoseconds, load divider
        logic div_step;  // one restoring division step
        logic load_ns;   // latch fraction lost, estimate the DLSR fraction
        logic ns_fix;    // correct the DLSR fraction estimate
        logic publish;   // move the finished report into the output registers
    } rrb_cmd_t;

endpackage : rrb_pkg
`default_nettype wire

// File: rtl/rtcp_reception_report_block.sv
// Top level of the RTCP reception report block: controller plus datapath.
//
// Request channel (req_valid/req_ready) takes one report request item: the
// stream statistics, the last sender report data and the two time stamps.
// Report channel (rpt_valid/rpt_ready) gives one report block item for each
// request: SSRC, loss word, highest sequence, jitter, LSR and DLSR.
// Work on an item runs through a setup step, 8 restoring-division steps
// for the fraction lost, the reciprocal estimate of the DLSR fraction, its
// correction and a finish step, in that order. Requests are taken one at
// a time: a new one only once the controller is back in idle.
// The finished report sits in output registers, so the next request is
// taken while the report waits. If the receiver stalls, the next report
// holds in the finish step until the output register is free.
// Reset clears the previous expected and received totals to zero, empties
// the output register and returns the controller to idle.
`default_nettype none
module rtcp_reception_report_block (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire logic [rrb_pkg::WORD_W-1:0]  source_ssrc,
    input  wire logic [rrb_pkg::WORD_W-1:0]  expected_count,
    input  wire logic [rrb_pkg::WORD_W-1:0]  received_count,
    input  wire logic [rrb_pkg::WORD_W-1:0]  highest_seq_ext,
    input  wire logic [rrb_pkg::WORD_W-1:0]  jitter_scaled,
    input  wire logic                        sender_report_seen,
    input  wire logic [rrb_pkg::WORD_W-1:0]  sender_report_source,
    input  wire logic [rrb_pkg::WORD_W-1:0]  lsr_value,
    input  wire logic [rrb_pkg::WORD_W-1:0]  now_sec,
    input  wire logic [rrb_pkg::NS_W-1:0]    now_nsec,
    input  wire logic [rrb_pkg::WORD_W-1:0]  arrival_sec,
    input  wire logic [rrb_pkg::NS_W-1:0]    arrival_nsec,
    output logic                             rpt_valid,
    input  wire logic                        rpt_ready,
    output logic      [rrb_pkg::WORD_W-1:0]  report_ssrc,
    output logic      [rrb_pkg::WORD_W-1:0]  loss_word,
    output logic      [rrb_pkg::WORD_W-1:0]  report_highest_seq,
    output logic      [rrb_pkg::JIT_W-1:0]   report_jitter,
    output logic      [rrb_pkg::WORD_W-1:0]  last_sr_stamp,
    output logic      [rrb_pkg::WORD_W-1:0]  delay_since_sr
);
    import rrb_pkg::*;

    rrb_cmd_t cmd;

    // Sequence the work on one item
    rrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .cmd       (cmd)
    );

    // Compute the report block
    rrb_datapath u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .source_ssrc          (source_ssrc),
        .expected_count       (expected_count),
        .received_count       (received_count),
        .highest_seq_ext      (highest_seq_ext),
        .jitter_scaled        (jitter_scaled),
        .sender_report_seen   (sender_report_seen),
        .sender_report_source (sender_report_source),
        .lsr_value            (lsr_value),
        .now_sec              (now_sec),
        .now_nsec             (now_nsec),
        .arrival_sec          (arrival_sec),
        .arrival_nsec         (arrival_nsec),
        .report_ssrc          (report_ssrc),
        .loss_word            (loss_word),
        .report_highest_seq   (report_highest_seq),
        .report_jitter        (report_jitter),
        .last_sr_stamp        (last_sr_stamp),
        .delay_since_sr       (delay_since_sr)
    );

endmodule : rtcp_reception_report_block
`default_nettype wire

// File: rtl/rrb_datapath.sv
// Datapath of the RTCP reception report block: capture, loss terms, divider, outputs.
`default_nettype none
module rrb_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rrb_pkg::rrb_cmd_t           cmd,
    input  wire logic [rrb_pkg::WORD_W-1:0]  source_ssrc,
    input  wire logic [rrb_pkg::WORD_W-1:0]  expected_count,
    input  wire logic [rrb_pkg::WORD_W-1:0]  received_count,
    input  wire logic [rrb_pkg::WORD_W-1:0]  highest_seq_ext,
    input  wire logic [rrb_pkg::WORD_W-1:0]  jitter_scaled,
    input  wire logic                        sender_report_seen,
    input  wire logic [rrb_pkg::WORD_W-1:0]  sender_report_source,
    input  wire logic [rrb_pkg::WORD_W-1:0]  lsr_value,
    input  wire logic [rrb_pkg::WORD_W-1:0]  now_sec,
    input  wire logic [rrb_pkg::NS_W-1:0]    now_nsec,
    input  wire logic [rrb_pkg::WORD_W-1:0]  arrival_sec,
    input  wire logic [rrb_pkg::NS_W-1:0]    arrival_nsec,
    output logic      [rrb_pkg::WORD_W-1:0]  report_ssrc,
    output logic      [rrb_pkg::WORD_W-1:0]  loss_word,
    output logic      [rrb_pkg::WORD_W-1:0]  report_highest_seq,
    output logic      [rrb_pkg::JIT_W-1:0]   report_jitter,
    output logic      [rrb_pkg::WORD_W-1:0]  last_sr_stamp,
    output logic      [rrb_pkg::WORD_W-1:0]  delay_since_sr
);
    import rrb_pkg::*;

    // Previous totals (block state)
    logic [WORD_W-1:0] prev_exp_reg;
    logic [WORD_W-1:0] prev_rcv_reg;

    // Captured request terms
    logic [WORD_W-1:0] ssrc_reg;
    logic [WORD_W-1:0] hseq_reg;
    logic [JIT_W-1:0]  jit_reg;
    logic [WORD_W-1:0] lsr_reg;
    logic              match_reg;
    logic [WORD_W-1:0] d_exp_reg;
    logic [WORD_W-1:0] d_rcv_reg;
    logic [WORD_W-1:0] cum_diff_reg;
    logic [DLSR_W-1:0] secs_reg;
    logic [NS_W:0]     ns_diff_reg;

    // Setup results
    logic [CUM_W-1:0]  cum_reg;
    logic              frac_zero_reg;
    logic              frac_sat_reg;
    logic [NS_W-1:0]   ns_clamp_reg;
    logic [DLSR_W-1:0] secs_adj_reg;
    logic [FRAC_W-1:0] frac_reg;

    // Restoring divider for the fraction lost
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] div_reg;
    logic [FRAC_W-1:0] quo_reg;

    // DLSR fraction estimate and corrected value
    logic [DLSR_W-1:0] ns_est_reg;
    logic [DLSR_W-1:0] ns_frac_reg;

    // Output registers
    logic [WORD_W-1:0] report_ssrc_reg;
    logic [WORD_W-1:0] loss_word_reg;
    logic [WORD_W-1:0] report_highest_seq_reg;
    logic [JIT_W-1:0]  report_jitter_reg;
    logic [WORD_W-1:0] last_sr_stamp_reg;
    logic [WORD_W-1:0] delay_since_sr_reg;

    logic [WORD_W-1:0]         newly;
    logic                      newly_pos;
    logic [WORD_W-1:0]         ns_ext;
    logic [WORD_W-1:0]         ns_borrow;
    logic [NS_W-1:0]           ns_clamp_next;
    logic                      cum_over;
    logic                      cum_under;
    logic [CUM_W-1:0]          cum_next;
    logic [WORD_W:0]           rem_shift;
    logic [WORD_W:0]           rem_sub;
    logic [NS_W+RECIP_W-1:0]   ns_prod;
    logic [SCALE_W-1:0]        est_prod;
    logic [SCALE_W-1:0]        ns_rem;
    logic [DLSR_W-1:0]         ns_frac_next;

    // Interval loss terms
    always_comb
    begin
        newly     = d_exp_reg - d_rcv_reg;
        newly_pos = !newly[WORD_W-1] && (newly != '0);
    end

    // Saturate cumulative loss to signed 24 bits
    always_comb
    begin
        cum_over  = !cum_diff_reg[WORD_W-1] && (cum_diff_reg[WORD_W-2:CUM_W-1] != '0);
        cum_under = cum_diff_reg[WORD_W-1] && (cum_diff_reg[WORD_W-2:CUM_W-1] != '1);
        if (cum_over)
        begin
            cum_next = CUM_MAX;
        end
        else if (cum_under)
        begin
            cum_next = CUM_MIN;
        end
        else
        begin
            cum_next = cum_diff_reg[CUM_W-1:0];
        end
    end

    // Borrow one second when the nanosecond difference is negative, then clamp
    always_comb
    begin
        ns_ext    = {{(WORD_W-NS_W-1){ns_diff_reg[NS_W]}}, ns_diff_reg};
        ns_borrow = ns_ext[WORD_W-1] ? (ns_ext + NS_PER_SEC) : ns_ext;
        if (ns_borrow[WORD_W-1])
        begin
            ns_clamp_next = '0;
        end
        else if (ns_borrow > NS_MAX)
        begin
            ns_clamp_next = NS_MAX[NS_W-1:0];
        end
        else
        begin
            ns_clamp_next = ns_borrow[NS_W-1:0];
        end
    end

    // One restoring division step: a remainder that starts below the divisor stays below it
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_sub   = rem_shift - {1'b0, div_reg};
    end

    // DLSR fraction by reciprocal, then add one when the remainder reaches a unit
    always_comb
    begin
        ns_prod      = {{RECIP_W{1'b0}}, ns_clamp_reg} * {{NS_W{1'b0}}, NS_RECIP};
        est_prod     = {{(SCALE_W-DLSR_W){1'b0}}, ns_est_reg}
                       * {{(SCALE_W-UNIT_W){1'b0}}, NS_UNIT};
        ns_rem       = {ns_clamp_reg, {(SCALE_W-NS_W){1'b0}}} - est_prod;
        ns_frac_next = (ns_rem >= {{(SCALE_W-UNIT_W){1'b0}}, NS_UNIT})
                       ? (ns_est_reg + 1'b1) : ns_est_reg;
    end

    // Hold previous totals across requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_exp_reg <= '0;
            prev_rcv_reg <= '0;
        end
        else if (cmd.capture)
        begin
            prev_exp_reg <= expected_count;
            prev_rcv_reg <= received_count;
        end
    end

    // Capture request and the differences that need the old totals
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ssrc_reg     <= source_ssrc;
            hseq_reg     <= highest_seq_ext;
            jit_reg      <= jitter_scaled[WORD_W-1:WORD_W-JIT_W];
            lsr_reg      <= lsr_value;
            match_reg    <= sender_report_seen && (sender_report_source == source_ssrc);
            d_exp_reg    <= expected_count - prev_exp_reg;
            d_rcv_reg    <= received_count - prev_rcv_reg;
            cum_diff_reg <= expected_count - received_count;
            secs_reg     <= now_sec[DLSR_W-1:0] - arrival_sec[DLSR_W-1:0];
            ns_diff_reg  <= {1'b0, now_nsec} - {1'b0, arrival_nsec};
        end
    end

    // Form loss terms and elapsed time, load divider for fraction lost
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            cum_reg       <= cum_next;
            frac_zero_reg <= (d_exp_reg == '0) || !newly_pos;
            frac_sat_reg  <= newly >= d_exp_reg;
            ns_clamp_reg  <= ns_clamp_next;
            secs_adj_reg  <= secs_reg - {{(DLSR_W-1){1'b0}}, ns_ext[WORD_W-1]};
        end
    end

    // Run the divider
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            rem_reg <= newly;
            div_reg <= d_exp_reg;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[WORD_W])
            begin
                rem_reg <= rem_sub[WORD_W-1:0];
                quo_reg <= {quo_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[WORD_W-1:0];
                quo_reg <= {quo_reg[FRAC_W-2:0], 1'b0};
            end
        end
    end

    // Estimate the DLSR fraction, then correct it
    always_ff @(posedge clk)
    begin
        if (cmd.load_ns)
        begin
            ns_est_reg <= ns_prod[RECIP_SH+DLSR_W-1:RECIP_SH];
        end
        if (cmd.ns_fix)
        begin
            ns_frac_reg <= ns_frac_next;
        end
    end

    // Latch fraction lost, forcing the zero and saturated cases
    always_ff @(posedge clk)
    begin
        if (cmd.load_ns)
        begin
            if (frac_zero_reg)
            begin
                frac_reg <= '0;
            end
            else if (frac_sat_reg)
            begin
                frac_reg <= FRAC_SAT;
            end
            else
            begin
                frac_reg <= quo_reg;
            end
        end
    end

    // Publish the report block
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            report_ssrc_reg        <= ssrc_reg;
            loss_word_reg          <= {frac_reg, cum_reg};
            report_highest_seq_reg <= hseq_reg;
            report_jitter_reg      <= jit_reg;
            last_sr_stamp_reg      <= match_reg ? lsr_reg : '0;
            delay_since_sr_reg     <= match_reg ? {secs_adj_reg, ns_frac_reg} : '0;
        end
    end

    assign report_ssrc        = report_ssrc_reg;
    assign loss_word          = loss_word_reg;
    assign report_highest_seq = report_highest_seq_reg;
    assign report_jitter      = report_jitter_reg;
    assign last_sr_stamp      = last_sr_stamp_reg;
    assign delay_since_sr     = delay_since_sr_reg;

endmodule : rrb_datapath
`default_nettype wire

// File: rtl/rrb_ctrl.sv
// Controller of the RTCP reception report block: sequences capture, division and output.
`default_nettype none
module rrb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rpt_valid,
    input  wire logic              rpt_ready,
    output rrb_pkg::rrb_cmd_t      cmd
);
    import rrb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_FRAC,
        ST_LOAD_NS,
        ST_FIX_NS,
        ST_FINISH
    } state_t;

    localparam logic [CNT_W-1:0] FRAC_LAST = CNT_W'(FRAC_STEPS - 1);

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             rpt_valid_reg;
    logic             out_free;

    assign out_free  = !rpt_valid_reg || rpt_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rpt_valid = rpt_valid_reg;

    // Decode datapath commands
    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == ST_IDLE) && req_valid;
        cmd.setup    = (state_reg == ST_SETUP);
        cmd.div_step = (state_reg == ST_DIV_FRAC);
        cmd.load_ns  = (state_reg == ST_LOAD_NS);
        cmd.ns_fix   = (state_reg == ST_FIX_NS);
        cmd.publish  = (state_reg == ST_FINISH) && out_free;
    end

    // Advance state, step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            if (rpt_valid_reg && rpt_ready && !cmd.publish)
            begin
                rpt_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV_FRAC;
                end
                ST_DIV_FRAC:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == FRAC_LAST)
                    begin
                        state_reg <= ST_LOAD_NS;
                    end
                end
                ST_LOAD_NS:
                begin
                    state_reg <= ST_FIX_NS;
                end
                ST_FIX_NS:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        rpt_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule : rrb_ctrl
`default_nettype wire

// File: rtl/rrb_checker.sv
// Port-level checker for the RTCP reception report block, with its bind.
`default_nettype none
module rrb_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    input  wire logic                        req_ready,
    input  wire logic                        rpt_valid,
    input  wire logic                        rpt_ready,
    input  wire logic [rrb_pkg::WORD_W-1:0]  report_ssrc,
    input  wire logic [rrb_pkg::WORD_W-1:0]  loss_word,
    input  wire logic [rrb_pkg::WORD_W-1:0]  delay_since_sr
);
    import rrb_pkg::*;

    // Hold a stalled report
    assert property (@(posedge clk) disable iff (!rst_n)
        (rpt_valid && !rpt_ready) |=> rpt_valid)
        else $error("report item dropped while stalled");

    // Keep a stalled report's payload unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (rpt_valid && !rpt_ready) |=>
            ($stable(report_ssrc) && $stable(loss_word) && $stable(delay_since_sr)))
        else $error("report payload changed while stalled");

    // Drop ready once a request item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while an item is at work");

    // A new report appears only as the controller returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rpt_valid) |-> (req_ready && !$past(req_ready)))
        else $error("report raised outside the finish step");

endmodule : rrb_checker

bind rtcp_reception_report_block rrb_checker u_rrb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .rpt_valid      (rpt_valid),
    .rpt_ready      (rpt_ready),
    .report_ssrc    (report_ssrc),
    .loss_word      (loss_word),
    .delay_since_sr (delay_since_sr)
);
`default_nettype wire
